FILE: hw/rtl/ccfr_pkg.sv
// shared types, constants and the crc step for the cobs/crc frame receiver
package ccfr_pkg;

    localparam int MAX_PAYLOAD  = 256;
    localparam int HDR_LEN      = 10;
    localparam int FRAME_CAP    = MAX_PAYLOAD + 12;
    localparam int CNT_W        = $clog2(FRAME_CAP + 1);
    localparam int HDR_IDX_W    = $clog2(HDR_LEN);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  CODE_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_TYPE_MASK  = 2'd2;

    // frame status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_COBS_ERROR   = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_TYPE = 3'd4;
    localparam logic [2:0] ST_BAD_CRC      = 3'd5;

    // one decoded event from the front end
    typedef struct packed {
        logic       is_end;
        logic       cobs_err;
        logic [7:0] data;
    } ev_t;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [8:0]  payload_capacity;
        logic [63:0] known_type_mask;
    } cfg_t;

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
            else       r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/cobs_crc_frame_receiver_core.sv
// top level of the cobs/crc frame receiver with its configuration registers
// Takes one cobs-encoded link byte per cycle (0x00 ends a frame) and sustains
// one byte per cycle while in_stall is low. A cobs front end decodes each byte
// combinationally and pushes at most one event into a four-entry queue; the
// back end pops one event per cycle while out_stall allows, updates header, crc
// and length state and loads the output register, which carries payload bytes
// and end-of-frame status. in_stall rises only when the queue is full, which
// happens only while out_stall holds the output register. Payload bytes are
// forwarded as they decode; the consumer drops them unless the following status
// is ok. Configuration writes are always taken (cfg_ready is high); change them
// only while the block is idle. No clearing pass is needed after reset.
module cobs_crc_frame_receiver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_frame_end,
    output logic [7:0]                     payload_byte,
    output logic [2:0]                     frame_status,
    output logic [7:0]                     frame_version,
    output logic [7:0]                     message_type,
    output logic [15:0]                    sequence_number,
    output logic [15:0]                    payload_length,
    output logic [31:0]                    sender_uptime_ms,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import ccfr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    ev_t  push_data, pop_data;
    logic push, full, pop, empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: cfg_next.expected_version = cfg_data[7:0];
                CFG_PAYLOAD_CAPACITY: cfg_next.payload_capacity = cfg_data[8:0];
                CFG_KNOWN_TYPE_MASK:  cfg_next.known_type_mask  = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.payload_capacity <= 9'd256;
            cfg_reg.known_type_mask  <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ccfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    ccfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ccfr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_empty          (empty),
        .q_data           (pop_data),
        .q_pop            (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_frame_end     (is_frame_end),
        .payload_byte     (payload_byte),
        .frame_status     (frame_status),
        .frame_version    (frame_version),
        .message_type     (message_type),
        .sequence_number  (sequence_number),
        .payload_length   (payload_length),
        .sender_uptime_ms (sender_uptime_ms)
    );

endmodule

FILE: hw/rtl/ccfr_front.sv
// cobs front end: turns link bytes into decoded-byte and end-of-frame events
module ccfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          q_push,
    output ccfr_pkg::ev_t q_data
);
    import ccfr_pkg::*;

    logic [7:0] block_left_reg, block_left_next;
    logic       prev_short_reg, prev_short_next;
    logic       seen_reg, seen_next;
    logic       take;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    always_comb
    begin
        block_left_next = block_left_reg;
        prev_short_next = prev_short_reg;
        seen_next       = seen_reg;
        q_push          = 1'b0;
        q_data          = '0;
        if (take)
        begin
            if (rx_byte == 8'h00)
            begin
                q_push          = 1'b1;
                q_data.is_end   = 1'b1;
                q_data.cobs_err = !seen_reg || (block_left_reg != 8'h00);
                block_left_next = 8'h00;
                prev_short_next = 1'b0;
                seen_next       = 1'b0;
            end
            else if (block_left_reg == 8'h00)
            begin
                // code byte: implied zero after a short block
                q_push          = seen_reg && prev_short_reg;
                seen_next       = 1'b1;
                prev_short_next = (rx_byte != CODE_MAX);
                block_left_next = rx_byte - 8'd1;
            end
            else
            begin
                q_push          = 1'b1;
                q_data.data     = rx_byte;
                block_left_next = block_left_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_left_reg <= 8'h00;
            prev_short_reg <= 1'b0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            block_left_reg <= block_left_next;
            prev_short_reg <= prev_short_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/ccfr_queue.sv
// small event queue between the cobs front end and the frame back end
module ccfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ccfr_pkg::ev_t push_data,
    output logic          full,
    input  logic          pop,
    output ccfr_pkg::ev_t pop_data,
    output logic          empty
);
    import ccfr_pkg::*;

    ev_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ccfr_back.sv
// frame back end: header capture, crc, payload forwarding and end-of-frame checks
module ccfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ccfr_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  ccfr_pkg::ev_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          is_frame_end,
    output logic [7:0]    payload_byte,
    output logic [2:0]    frame_status,
    output logic [7:0]    frame_version,
    output logic [7:0]    message_type,
    output logic [15:0]   sequence_number,
    output logic [15:0]   payload_length,
    output logic [31:0]   sender_uptime_ms
);
    import ccfr_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(FRAME_CAP);
    localparam logic [CNT_W-1:0] HDR_C = CNT_W'(HDR_LEN);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      tail_reg, tail_next;

    logic             out_valid_reg, out_valid_next;
    logic             end_reg;
    logic [7:0]       pbyte_reg;
    logic [2:0]       status_reg;
    logic [7:0]       ver_reg, typ_reg;
    logic [15:0]      seq_reg, plen_out_reg;
    logic [31:0]      up_reg;

    logic             res_valid, res_end;
    logic [7:0]       res_byte;
    logic [2:0]       res_status;
    logic             load;
    logic [15:0]      plen;
    logic [CNT_W-1:0] pos;

    assign load  = !out_valid_reg || !out_stall;
    assign q_pop = load && !q_empty;
    assign plen  = {hdr_reg[5], hdr_reg[4]};
    assign pos   = count_reg - HDR_C;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hdr_next   = hdr_reg;
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        res_valid  = 1'b0;
        res_end    = 1'b0;
        res_byte   = 8'h00;
        res_status = ST_OK;
        if (q_pop)
        begin
            if (q_data.is_end)
            begin
                res_valid = 1'b1;
                res_end   = 1'b1;
                if (q_data.cobs_err || ovf_reg || (count_reg == '0))
                    res_status = ST_COBS_ERROR;
                else if (count_reg < CNT_W'(HDR_LEN + 2))
                    res_status = ST_BAD_LENGTH;
                else if ((plen > 16'(MAX_PAYLOAD))
                         || (({1'b0, plen} + 17'd12) != 17'(count_reg)))
                    res_status = ST_BAD_LENGTH;
                else if (hdr_reg[0] != cfg.expected_version)
                    res_status = ST_BAD_VERSION;
                else if ((hdr_reg[1][7:6] != 2'b00)
                         || !cfg.known_type_mask[hdr_reg[1][5:0]])
                    res_status = ST_UNKNOWN_TYPE;
                else if (tail_reg != crc_reg)
                    res_status = ST_BAD_CRC;
                else if (plen > {7'd0, cfg.payload_capacity})
                    res_status = ST_BAD_LENGTH;
                // start the next frame clean
                count_next = '0;
                ovf_next   = 1'b0;
                for (int i = 0; i < HDR_LEN; i++) hdr_next[i] = 8'h00;
                crc_next   = CRC_INIT;
                tail_next  = 16'h0000;
            end
            else if (!ovf_reg)
            begin
                if (count_reg >= CAP_C)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (count_reg < HDR_C)
                        hdr_next[count_reg[HDR_IDX_W-1:0]] = q_data.data;
                    tail_next = {q_data.data, tail_reg[15:8]};
                    // crc trails the stream by two bytes, the received crc
                    if (count_reg >= CNT_W'(2))
                        crc_next = crc_feed(crc_reg, tail_reg[7:0]);
                    count_next = count_reg + 1'b1;
                    if ((count_reg >= HDR_C) && (16'(pos) < plen))
                    begin
                        res_valid = 1'b1;
                        res_byte  = q_data.data;
                    end
                end
            end
        end
        out_valid_next = load ? res_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            for (int i = 0; i < HDR_LEN; i++) hdr_reg[i] <= 8'h00;
            crc_reg       <= CRC_INIT;
            tail_reg      <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hdr_reg       <= hdr_next;
            crc_reg       <= crc_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            end_reg    <= res_end;
            pbyte_reg  <= res_byte;
            status_reg <= res_status;
            if (res_end && (res_status == ST_OK))
            begin
                ver_reg      <= hdr_reg[0];
                typ_reg      <= hdr_reg[1];
                seq_reg      <= {hdr_reg[3], hdr_reg[2]};
                plen_out_reg <= plen;
                up_reg       <= {hdr_reg[9], hdr_reg[8], hdr_reg[7], hdr_reg[6]};
            end
            else
            begin
                ver_reg      <= 8'h00;
                typ_reg      <= 8'h00;
                seq_reg      <= 16'h0000;
                plen_out_reg <= 16'h0000;
                up_reg       <= 32'h0000_0000;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_frame_end     = end_reg;
    assign payload_byte     = pbyte_reg;
    assign frame_status     = status_reg;
    assign frame_version    = ver_reg;
    assign message_type     = typ_reg;
    assign sequence_number  = seq_reg;
    assign payload_length   = plen_out_reg;
    assign sender_uptime_ms = up_reg;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for cobs_crc_frame_receiver_core with its own frame decoder model
module tb;
    import ccfr_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BYTES = 150;

    typedef logic [7:0] octet_q_t[$];

    typedef struct {
        logic        is_end;
        logic [7:0]  data;
        logic [2:0]  status;
        logic [7:0]  version;
        logic [7:0]  msg_type;
        logic [15:0] seq;
        logic [15:0] length;
        logic [31:0] uptime;
    } rx_event_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 is_frame_end;
    logic [7:0]           payload_byte;
    logic [2:0]           frame_status;
    logic [7:0]           frame_version;
    logic [7:0]           message_type;
    logic [15:0]          sequence_number;
    logic [15:0]          payload_length;
    logic [31:0]          sender_uptime_ms;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    // register copies
    logic [7:0]  cfg_version;
    logic [8:0]  cfg_capacity;
    logic [63:0] cfg_type_mask;

    // decoder model state
    logic [7:0]  blk_remaining;
    bit          last_code_short;
    bit          code_seen;
    int unsigned frame_count;
    bit          frame_overflow;
    logic [7:0]  hdr_bytes [HDR_LEN];
    logic [15:0] crc_run;
    logic [15:0] last_two;

    rx_event_t expected_events[$];
    int        failures = 0;
    int        hold_request = 0;
    int        bytes_sent = 0;
    bit        sender_steady = 0;

    cobs_crc_frame_receiver_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_frame_end     (is_frame_end),
        .payload_byte     (payload_byte),
        .frame_status     (frame_status),
        .frame_version    (frame_version),
        .message_type     (message_type),
        .sequence_number  (sequence_number),
        .payload_length   (payload_length),
        .sender_uptime_ms (sender_uptime_ms),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // crc-16/ccitt-false, bit-serial msb first
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        int          i;
        r = c;
        for (i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic model_clear_frame();
        blk_remaining = '0;
        last_code_short = 0;
        code_seen = 0;
        frame_count = 0;
        frame_overflow = 0;
        foreach (hdr_bytes[i])
            hdr_bytes[i] = '0;
        crc_run = CRC_INIT;
        last_two = '0;
    endtask

    task automatic model_store_decoded(input logic [7:0] b);
        int unsigned pos;
        rx_event_t   ev;
        pos = frame_count;
        if (frame_overflow)
            return;
        if (pos >= FRAME_CAP)
        begin
            frame_overflow = 1;
            return;
        end
        if (pos < HDR_LEN)
            hdr_bytes[pos] = b;
        // the crc trails the decode by two bytes so the received crc stays out of it
        if (pos >= 2)
            crc_run = crc16_next(crc_run, last_two[7:0]);
        last_two = {b, last_two[15:8]};
        frame_count = pos + 1;
        if (pos >= HDR_LEN && (pos - HDR_LEN) < {hdr_bytes[5], hdr_bytes[4]})
        begin
            ev = '{default: '0};
            ev.data = b;
            expected_events.push_back(ev);
        end
    endtask

    task automatic model_close_frame();
        rx_event_t   ev;
        logic [15:0] plen;
        ev = '{default: '0};
        ev.is_end = 1'b1;
        plen = {hdr_bytes[5], hdr_bytes[4]};
        if (!code_seen || blk_remaining != 0 || frame_overflow || frame_count == 0)
            ev.status = ST_COBS_ERROR;
        else if (frame_count < 12 || plen > MAX_PAYLOAD || plen + 12 != frame_count)
            ev.status = ST_BAD_LENGTH;
        else if (hdr_bytes[0] != cfg_version)
            ev.status = ST_BAD_VERSION;
        else if (hdr_bytes[1] > 63 || !cfg_type_mask[hdr_bytes[1][5:0]])
            ev.status = ST_UNKNOWN_TYPE;
        else if (last_two != crc_run)
            ev.status = ST_BAD_CRC;
        else if (plen > cfg_capacity)
            ev.status = ST_BAD_LENGTH;
        else
        begin
            ev.status = ST_OK;
            ev.version = hdr_bytes[0];
            ev.msg_type = hdr_bytes[1];
            ev.seq = {hdr_bytes[3], hdr_bytes[2]};
            ev.length = plen;
            ev.uptime = {hdr_bytes[9], hdr_bytes[8], hdr_bytes[7], hdr_bytes[6]};
        end
        expected_events.push_back(ev);
    endtask

    task automatic model_rx_byte(input logic [7:0] b);
        if (b == 8'h00)
        begin
            model_close_frame();
            model_clear_frame();
        end
        else if (blk_remaining == 0)
        begin
            // a block after a short one starts with an implied zero
            if (code_seen && last_code_short)
                model_store_decoded(8'h00);
            code_seen = 1;
            last_code_short = (b != CODE_MAX);
            blk_remaining = b - 8'd1;
        end
        else
        begin
            blk_remaining--;
            model_store_decoded(b);
        end
    endtask

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_result();
        rx_event_t ev;
        if (expected_events.size() == 0)
        begin
            report_failure($sformatf("unexpected result end=%0b byte=%02h status=%0d",
                is_frame_end, payload_byte, frame_status));
            return;
        end
        ev = expected_events.pop_front();
        if (is_frame_end !== ev.is_end || payload_byte !== ev.data ||
            frame_status !== ev.status || frame_version !== ev.version ||
            message_type !== ev.msg_type || sequence_number !== ev.seq ||
            payload_length !== ev.length || sender_uptime_ms !== ev.uptime)
            report_failure($sformatf({"mismatch: expected end=%0b byte=%02h st=%0d ver=%02h ",
                "typ=%02h seq=%04h len=%04h up=%08h, got end=%0b byte=%02h st=%0d ver=%02h ",
                "typ=%02h seq=%04h len=%04h up=%08h"},
                ev.is_end, ev.data, ev.status, ev.version, ev.msg_type, ev.seq, ev.length,
                ev.uptime, is_frame_end, payload_byte, frame_status, frame_version,
                message_type, sequence_number, payload_length, sender_uptime_ms));
    endtask

    // result side: checks each transfer and drives out_stall
    initial
    begin : result_sink
        int stall_left;
        int ready_left;
        int pick;
        stall_left = 0;
        ready_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (ready_left > 0)
            begin
                out_stall = 1'b0;
                ready_left--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    out_stall = 1'b0;
                else if (pick < 85)
                begin
                    out_stall = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end
                else if (pick < 92)
                begin
                    out_stall = 1'b1;
                    stall_left = $urandom_range(4, 25);
                end
                else
                begin
                    out_stall = 1'b0;
                    ready_left = $urandom_range(20, 60);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("cobs_crc_frame_receiver_core test failed");
        $finish;
    end

    function automatic int sender_gap();
        int pick;
        if (sender_steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_link(input logic [7:0] b);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        rx_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        model_rx_byte(b);
        bytes_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            rx_byte = $urandom_range(0, 255);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_EXPECTED_VERSION: cfg_version = value[7:0];
            CFG_PAYLOAD_CAPACITY: cfg_capacity = value[8:0];
            CFG_KNOWN_TYPE_MASK:  cfg_type_mask = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all_registers(input logic [7:0] ver, input logic [8:0] cap,
                                     input logic [63:0] mask);
        set_register(CFG_EXPECTED_VERSION, {56'd0, ver});
        set_register(CFG_PAYLOAD_CAPACITY, {55'd0, cap});
        set_register(CFG_KNOWN_TYPE_MASK, mask);
    endtask

    function automatic octet_q_t random_body(input int n, input int zero_pct);
        octet_q_t q;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < zero_pct)
                q.push_back(8'h00);
            else
                q.push_back(8'($urandom_range(1, 255)));
        end
        return q;
    endfunction

    // decoded frame: header, body, then crc low byte first
    function automatic octet_q_t build_frame(input logic [7:0] ver, input logic [7:0] typ,
                                             input logic [15:0] seq, input logic [15:0] len_field,
                                             input logic [31:0] up, input octet_q_t body);
        octet_q_t    f;
        logic [15:0] crc;
        f = '{ver, typ, seq[7:0], seq[15:8], len_field[7:0], len_field[15:8],
              up[7:0], up[15:8], up[23:16], up[31:24]};
        foreach (body[i])
            f.push_back(body[i]);
        crc = CRC_INIT;
        foreach (f[i])
            crc = crc16_next(crc, f[i]);
        f.push_back(crc[7:0]);
        f.push_back(crc[15:8]);
        return f;
    endfunction

    function automatic octet_q_t cobs_encode(input octet_q_t raw);
        octet_q_t enc;
        octet_q_t blk;
        foreach (raw[i])
        begin
            if (raw[i] == 8'h00)
            begin
                enc.push_back(8'(blk.size() + 1));
                foreach (blk[j])
                    enc.push_back(blk[j]);
                blk.delete();
            end
            else
            begin
                blk.push_back(raw[i]);
                if (blk.size() == 254)
                begin
                    enc.push_back(CODE_MAX);
                    foreach (blk[j])
                        enc.push_back(blk[j]);
                    blk.delete();
                end
            end
        end
        enc.push_back(8'(blk.size() + 1));
        foreach (blk[j])
            enc.push_back(blk[j]);
        return enc;
    endfunction

    // link bytes then the delimiter
    task automatic send_raw(input octet_q_t link);
        foreach (link[i])
            send_link(link[i]);
        send_link(8'h00);
    endtask

    task automatic send_frame(input octet_q_t decoded);
        send_raw(cobs_encode(decoded));
    endtask

    task automatic test_valid_frames();
        octet_q_t body;
        octet_q_t frame;
        body.delete();
        send_frame(build_frame(8'h01, 8'h00, 16'h0000, 16'd0, 32'h0000_0000, body));
        body = '{8'h11, 8'h00, 8'h22};
        send_frame(build_frame(8'h01, 8'd63, 16'hFFFF, 16'd3, 32'hFFFF_FFFF, body));
        body = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(build_frame(8'h01, 8'h2A, 16'h8001, 16'd4, 32'h8000_0001, body));
        // maximum payload with no zeros forces full 0xff code blocks
        body = random_body(MAX_PAYLOAD, 0);
        send_frame(build_frame(8'h01, 8'h05, 16'h1234, 16'(MAX_PAYLOAD), 32'h0BAD_F00D, body));
        // zero right after a long block of 244 nonzero bytes
        body = random_body(244, 0);
        body.push_back(8'h00);
        body.push_back(8'h7F);
        frame = build_frame(8'h01, 8'h01, 16'h0001, 16'd246, 32'h1, body);
        send_frame(frame);
    endtask

    task automatic test_cobs_errors();
        octet_q_t link;
        octet_q_t body;
        link.delete();
        send_raw(link);                       // empty frame between delimiters
        link = '{8'h05, 8'h01, 8'h02};        // last block cut short
        send_raw(link);
        link = '{8'h01};                      // code byte only, nothing decoded
        send_raw(link);
        // overflow: payload emitted up to the length field, bytes past the cap dropped
        body = random_body(MAX_PAYLOAD + 40, 10);
        send_frame(build_frame(8'h01, 8'h00, 16'h0, 16'(MAX_PAYLOAD), 32'h0, body));
    endtask

    task automatic test_header_checks();
        octet_q_t link;
        octet_q_t body;
        octet_q_t frame;
        link = '{8'h04, 8'h01, 8'h02, 8'h03};
        send_raw(link);                       // fewer than 12 decoded bytes
        body = random_body(4, 20);
        send_frame(build_frame(8'h01, 8'h00, 16'h0, 16'd300, 32'h0, body));
        body = random_body(3, 20);
        send_frame(build_frame(8'h01, 8'h00, 16'h0, 16'd5, 32'h0, body));
        send_frame(build_frame(8'h02, 8'h00, 16'h0, 16'd3, 32'h0, body));
        send_frame(build_frame(8'h01, 8'd64, 16'h0, 16'd3, 32'h0, body));
        send_frame(build_frame(8'h01, 8'hFF, 16'h0, 16'd3, 32'h0, body));
        frame = build_frame(8'h01, 8'h03, 16'h0, 16'd3, 32'h0, body);
        frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h80;
        send_frame(frame);
    endtask

    task automatic test_register_settings();
        octet_q_t body;
        body.delete();
        set_all_registers(8'h00, 9'd0, 64'h0);
        send_frame(build_frame(8'h00, 8'h00, 16'h0, 16'd0, 32'h0, body));
        set_register(CFG_KNOWN_TYPE_MASK, 64'h1);
        send_frame(build_frame(8'h00, 8'h00, 16'h0, 16'd0, 32'h0, body));
        body = '{8'h5A};
        send_frame(build_frame(8'h00, 8'h00, 16'h0, 16'd1, 32'h0, body));  // over capacity
        set_all_registers(8'hFF, 9'd256, 64'h8000_0000_0000_0000);
        body = '{8'hA5, 8'h00};
        send_frame(build_frame(8'hFF, 8'd63, 16'hBEEF, 16'd2, 32'hCAFE_0000, body));
        send_frame(build_frame(8'hFF, 8'd62, 16'hBEEF, 16'd2, 32'hCAFE_0000, body));
        send_frame(build_frame(8'h01, 8'd63, 16'hBEEF, 16'd2, 32'hCAFE_0000, body));
        set_all_registers(8'h01, 9'd7, {64{1'b1}});
        body = random_body(7, 20);
        send_frame(build_frame(8'h01, 8'd9, 16'h7, 16'd7, 32'h7, body));
        body = random_body(8, 20);
        send_frame(build_frame(8'h01, 8'd9, 16'h8, 16'd8, 32'h8, body));
        set_register(CFG_PAYLOAD_CAPACITY, 64'd256);
    endtask

    task automatic test_backpressure();
        octet_q_t body;
        octet_q_t link;
        int       half;
        wait_drained();
        // receiver holds off while the sender streams, so the input stalls
        hold_request = HOLD_CYCLES;
        sender_steady = 1;
        repeat (3)
        begin
            body = random_body(20, 10);
            send_frame(build_frame(cfg_version, 8'd1, 16'($urandom), 16'd20, $urandom, body));
        end
        sender_steady = 0;
        // sender pauses mid-frame until everything has come out
        body = random_body(30, 10);
        link = cobs_encode(build_frame(cfg_version, 8'd2, 16'h55AA, 16'd30, $urandom, body));
        half = link.size() / 2;
        for (int i = 0; i < half; i++)
            send_link(link[i]);
        wait_drained();
        for (int i = half; i < link.size(); i++)
            send_link(link[i]);
        send_link(8'h00);
    endtask

    task automatic send_random_frame();
        octet_q_t    body;
        octet_q_t    frame;
        octet_q_t    link;
        int          pick;
        int          plen;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [15:0] len_field;
        pick = $urandom_range(0, 99);
        sender_steady = ($urandom_range(0, 99) < 20);
        if (pick < 78)
        begin
            ver = ($urandom_range(0, 99) < 85) ? cfg_version : 8'($urandom);
            typ = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 63)) : 8'($urandom);
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                 : $urandom_range(0, 12);
            len_field = 16'(plen);
            if ($urandom_range(0, 99) < 5)
                len_field = ($urandom_range(0, 1) == 1) ? 16'(plen + 1) : 16'($urandom);
            body = random_body(plen, 15);
            frame = build_frame(ver, typ, 16'($urandom), len_field, $urandom, body);
            if ($urandom_range(0, 99) < 10)
            begin
                pick = $urandom_range(0, frame.size() - 1);
                frame[pick] = frame[pick] ^ 8'($urandom_range(1, 255));
            end
            send_frame(frame);
        end
        else if (pick < 86)
        begin
            body = random_body($urandom_range(0, 8), 15);
            link = cobs_encode(build_frame(cfg_version, 8'd0, 16'h0, 16'(body.size()), 32'h0,
                                           body));
            repeat ($urandom_range(1, 3))
                void'(link.pop_back());
            send_raw(link);
        end
        else if (pick < 97)
        begin
            link.delete();
            repeat ($urandom_range(1, 20))
                link.push_back(8'($urandom_range(0, 255)));
            send_raw(link);
        end
        else
        begin
            body = random_body($urandom_range(MAX_PAYLOAD, MAX_PAYLOAD + 20), 5);
            send_frame(build_frame(cfg_version, 8'd0, 16'h0, 16'($urandom_range(0, 300)),
                                   32'h0, body));
        end
        sender_steady = 0;
    endtask

    task automatic test_random_traffic();
        int phase_end;
        int phase;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_all_registers(8'h01, 9'd256, {64{1'b1}});
                1: set_all_registers(8'($urandom), 9'($urandom_range(0, 256)),
                                     {$urandom, $urandom});
                2: set_all_registers(8'hFF, 9'd12, {$urandom, $urandom} | 64'hFF);
                3: set_all_registers(8'h00, 9'd5, {64{1'b1}});
                default: set_all_registers(8'h01, 9'd256, {64{1'b1}});
            endcase
            phase_end = bytes_sent + RANDOM_BYTES / 5;
            while (bytes_sent < phase_end)
                send_random_frame();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_EXPECTED_VERSION;
        cfg_data = 64'h0;
        cfg_version = 8'h01;
        cfg_capacity = 9'd256;
        cfg_type_mask = {64{1'b1}};
        model_clear_frame();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_valid_frames();
        test_cobs_errors();
        test_header_checks();
        test_register_settings();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (expected_events.size() != 0)
            report_failure($sformatf("%0d results never arrived", expected_events.size()));
        if (failures == 0)
            $display("cobs_crc_frame_receiver_core test passed");
        else
            $display("cobs_crc_frame_receiver_core test failed");
        $finish;
    end

endmodule
